// ===== rtl/msb_pkg.sv =====
// Shared constants and types of the masked sprite blitter.
`timescale 1ns / 1ps
package msb_pkg;

    // Framebuffer geometry.
    localparam int LINE_BYTES  = 16;
    localparam int LINES       = 128;
    localparam int STORE_BYTES = LINE_BYTES * LINES;
    localparam int ADDR_W      = $clog2(STORE_BYTES);

    // Field widths of the words on the channels.
    localparam int ACTION_W  = 2;
    localparam int ADDRESS_W = 11;
    localparam int BYTE_W    = 8;
    localparam int ROW_W     = 7;
    localparam int COL_W     = 4;
    localparam int POS_W     = 7;
    localparam int SHIFT_W   = 3;

    // Configuration port.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam int REG_POS_X = 0;
    localparam int REG_POS_Y = 1;

    // Action codes.
    localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_BLIT  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;

    // Value of every framebuffer byte after reset.
    localparam logic [BYTE_W-1:0] FILL_BYTE = 8'hFF;

    typedef struct packed {
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
    } t_cfg;

endpackage

// ===== rtl/msb_frame_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module msb_frame_ram #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/msb_engine.sv =====
// Sequencer that clears the framebuffer and runs byte writes, byte reads and read-modify-write blits against it.
`timescale 1ns / 1ps
module msb_engine (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  msb_pkg::t_cfg                    i_cfg,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [msb_pkg::ACTION_W-1:0]     i_action,
    input  logic [msb_pkg::ADDRESS_W-1:0]    i_address,
    input  logic [msb_pkg::BYTE_W-1:0]       i_write_byte,
    input  logic [msb_pkg::ROW_W-1:0]        i_sprite_row,
    input  logic [msb_pkg::COL_W-1:0]        i_sprite_col,
    input  logic [msb_pkg::BYTE_W-1:0]       i_sprite_data,
    input  logic [msb_pkg::BYTE_W-1:0]       i_sprite_mask,
    input  logic                             i_row_end,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [msb_pkg::BYTE_W-1:0]       o_read_data,
    output logic                             o_clipped
);

    localparam int AW = msb_pkg::ADDR_W;
    localparam int BW = msb_pkg::BYTE_W;
    localparam int LSW = msb_pkg::POS_W + 1;
    localparam int BCW = msb_pkg::COL_W + 1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_SPILL,
        S_WAIT
    } t_state;

    t_state r_state, n_state;

    logic [AW-1:0] r_clr, n_clr;

    // Latched item.
    logic [msb_pkg::ACTION_W-1:0] r_act;
    logic                         r_rd_ok;
    logic [AW-1:0]                r_addr;
    logic                         r_main_ok;
    logic                         r_spill_ok;
    logic                         r_col0;
    logic                         r_row_end;
    logic [msb_pkg::SHIFT_W-1:0]  r_shift;
    logic [BW-1:0]                r_data;
    logic [BW-1:0]                r_mask;

    // Carry into the next byte of the sprite line, and the spill byte.
    logic [BW-1:0] r_carry_p, n_carry_p;
    logic [BW-1:0] r_carry_m, n_carry_m;
    logic [BW-1:0] r_spill_p, n_spill_p;
    logic [BW-1:0] r_spill_m, n_spill_m;
    logic          r_clip, n_clip;

    // Result waiting for the output register, and the output register itself.
    logic [BW-1:0] r_pend_rd, n_pend_rd;
    logic          r_pend_clip, n_pend_clip;
    logic          r_out_valid, n_out_valid;
    logic [BW-1:0] r_out_rd, n_out_rd;
    logic          r_out_clip, n_out_clip;

    // Memory port controls.
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [BW-1:0] ram_wdata, ram_q;

    // Decode of the item on the input port.
    logic                  accept;
    logic                  in_addr_ok;
    logic [LSW-1:0]        line_sum;
    logic [BCW-1:0]        bcol;
    logic                  line_ok;
    logic                  main_ok;
    logic                  spill_ok;
    logic [AW-1:0]         blit_addr;

    // Merge datapath.
    logic [2*BW-1:0] shd, shm;
    logic [BW-1:0]   cur_p, cur_m, sd, sm;
    logic [BW-1:0]   fin_rd;
    logic            fin_clip;
    logic            finish;
    logic            out_free;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept = i_in_valid && o_in_ready;

    assign in_addr_ok = (int'(i_address) < msb_pkg::STORE_BYTES);
    assign line_sum = LSW'(i_cfg.pos_y) + LSW'(i_sprite_row);
    assign bcol = BCW'(i_cfg.pos_x[msb_pkg::POS_W-1:msb_pkg::SHIFT_W]) + BCW'(i_sprite_col);
    assign line_ok = (int'(line_sum) < msb_pkg::LINES);
    assign main_ok = line_ok && (int'(bcol) < msb_pkg::LINE_BYTES);
    assign spill_ok = line_ok && ((int'(bcol) + 1) < msb_pkg::LINE_BYTES);
    assign blit_addr = AW'(line_sum) * AW'(msb_pkg::LINE_BYTES) + AW'(bcol);

    // The upper byte of each wide shift is the shifted sprite byte, the lower
    // byte is what spills into the next byte column.
    assign shd = {r_data, BW'(0)} >> r_shift;
    assign shm = {r_mask, BW'(0)} >> r_shift;
    assign cur_p = r_col0 ? BW'(0) : r_carry_p;
    assign cur_m = r_col0 ? BW'(0) : r_carry_m;
    assign sd = shd[2*BW-1:BW] | cur_p;
    assign sm = shm[2*BW-1:BW] | cur_m;

    assign out_free = !r_out_valid || i_out_ready;

    msb_frame_ram #(
        .DEPTH(msb_pkg::STORE_BYTES),
        .WIDTH(BW)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_q)
    );

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_carry_p   = r_carry_p;
        n_carry_m   = r_carry_m;
        n_spill_p   = r_spill_p;
        n_spill_m   = r_spill_m;
        n_clip      = r_clip;
        n_pend_rd   = r_pend_rd;
        n_pend_clip = r_pend_clip;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_rd    = r_out_rd;
        n_out_clip  = r_out_clip;
        ram_we      = 1'b0;
        ram_waddr   = r_addr;
        ram_wdata   = msb_pkg::FILL_BYTE;
        ram_re      = 1'b0;
        ram_raddr   = r_addr;
        fin_rd      = '0;
        fin_clip    = 1'b0;
        finish      = 1'b0;

        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = msb_pkg::FILL_BYTE;
                n_clr     = r_clr + AW'(1);
                if (int'(r_clr) == msb_pkg::STORE_BYTES - 1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_LOOK;
                    ram_re  = 1'b1;
                    if (i_action == msb_pkg::ACT_BLIT) begin
                        ram_raddr = blit_addr;
                    end else begin
                        ram_raddr = AW'(i_address);
                    end
                    if (i_action == msb_pkg::ACT_WRITE && in_addr_ok) begin
                        ram_we    = 1'b1;
                        ram_waddr = AW'(i_address);
                        ram_wdata = i_write_byte;
                    end
                end
            end
            S_LOOK: begin
                if (r_act == msb_pkg::ACT_BLIT) begin
                    ram_we    = r_main_ok;
                    ram_waddr = r_addr;
                    ram_wdata = (ram_q & ~sm) | (sd & sm);
                    n_clip    = !r_main_ok;
                    n_spill_p = shd[BW-1:0];
                    n_spill_m = shm[BW-1:0];
                    if (r_row_end) begin
                        n_carry_p = '0;
                        n_carry_m = '0;
                    end else begin
                        n_carry_p = shd[BW-1:0];
                        n_carry_m = shm[BW-1:0];
                    end
                    if (r_row_end && (r_shift != '0)) begin
                        ram_re    = 1'b1;
                        ram_raddr = r_addr + AW'(1);
                        n_state   = S_SPILL;
                    end else begin
                        fin_clip = !r_main_ok;
                        finish   = 1'b1;
                    end
                end else begin
                    if (r_act == msb_pkg::ACT_READ && r_rd_ok) begin
                        fin_rd = ram_q;
                    end
                    finish = 1'b1;
                end
            end
            S_SPILL: begin
                ram_we    = r_spill_ok;
                ram_waddr = r_addr + AW'(1);
                ram_wdata = (ram_q & ~r_spill_m) | (r_spill_p & r_spill_m);
                fin_clip  = r_clip || !r_spill_ok;
                finish    = 1'b1;
            end
            S_WAIT: begin
                if (i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_rd    = r_pend_rd;
                    n_out_clip  = r_pend_clip;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // A finished result goes straight to the output register when it is
        // free, else it parks until the consumer takes the word in front.
        if (finish) begin
            if (out_free) begin
                n_out_valid = 1'b1;
                n_out_rd    = fin_rd;
                n_out_clip  = fin_clip;
                n_state     = S_IDLE;
            end else begin
                n_pend_rd   = fin_rd;
                n_pend_clip = fin_clip;
                n_state     = S_WAIT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_carry_p   <= '0;
            r_carry_m   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_carry_p   <= n_carry_p;
            r_carry_m   <= n_carry_m;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_act      <= i_action;
            r_rd_ok    <= in_addr_ok;
            r_addr     <= (i_action == msb_pkg::ACT_BLIT) ? blit_addr : AW'(i_address);
            r_main_ok  <= main_ok;
            r_spill_ok <= spill_ok;
            r_col0     <= (i_sprite_col == '0);
            r_row_end  <= i_row_end;
            r_shift    <= i_cfg.pos_x[msb_pkg::SHIFT_W-1:0];
            r_data     <= i_sprite_data;
            r_mask     <= i_sprite_mask;
        end
        r_spill_p   <= n_spill_p;
        r_spill_m   <= n_spill_m;
        r_clip      <= n_clip;
        r_pend_rd   <= n_pend_rd;
        r_pend_clip <= n_pend_clip;
        r_out_rd    <= n_out_rd;
        r_out_clip  <= n_out_clip;
    end

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_out_rd;
    assign o_clipped   = r_out_clip;

`ifndef SYNTHESIS
    a_wait_needs_full_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAIT) |-> r_out_valid)
        else $error("result parked while the output register is empty");

    a_clip_has_no_read_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_clip) |-> (r_out_rd == '0))
        else $error("clipped word carries read data");

    a_spill_leaves_no_carry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SPILL) |=> ((r_carry_p == '0) && (r_carry_m == '0)))
        else $error("carry survived the end of a sprite line");

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |=> !$past(accept))
        else $error("word accepted during the clearing pass");
`endif

endmodule

// ===== rtl/masked_sprite_blitter_1bpp_core.sv =====
// Top level of the masked one-bit sprite blitter: configuration registers and engine.
`timescale 1ns / 1ps
// The block keeps a 128-line by 16-byte one-bit framebuffer in a synchronous
// memory and processes one input word at a time: a byte write, a byte read,
// or the blit of one sprite byte with its opacity mask at the position held
// in the pos_x and pos_y registers. After reset the block runs a clearing
// pass that fills all 2048 framebuffer bytes with 0xFF, one byte per cycle,
// with o_in_ready low until it ends; configuration writes are taken during
// that time as always. Afterwards a write, read or unused action passes
// through the S_LOOK state, and a blit through S_LOOK too, or also through
// S_SPILL on the last byte of a sprite line when pos_x is not a multiple of
// 8, because the spill byte needs a second read-modify-write. These steps
// are set by the read-modify-write through the registered read of the frame
// memory. Every word produces exactly one result word; the result sits in
// an output register, so the next input word is accepted while the previous
// result still waits to be taken. The sprite carry between consecutive bytes
// of one line is held inside the block and is cleared by byte column zero and
// after the last byte of a line. Blit writes that fall outside the
// framebuffer are dropped and flagged on o_clipped; out-of-range addresses
// for byte writes are ignored and read back as zero. Registers sit at byte
// addresses 0 (pos_x) and 4 (pos_y) and should be written only while the
// block is idle.
module masked_sprite_blitter_1bpp_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration port.
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [msb_pkg::PADDR_W-1:0]       paddr,
    input  logic [msb_pkg::PDATA_W-1:0]       pwdata,
    output logic [msb_pkg::PDATA_W-1:0]       prdata,
    output logic                              pready,
    // Input words.
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [msb_pkg::ACTION_W-1:0]      i_action,
    input  logic [msb_pkg::ADDRESS_W-1:0]     i_address,
    input  logic [msb_pkg::BYTE_W-1:0]        i_write_byte,
    input  logic [msb_pkg::ROW_W-1:0]         i_sprite_row,
    input  logic [msb_pkg::COL_W-1:0]         i_sprite_col,
    input  logic [msb_pkg::BYTE_W-1:0]        i_sprite_data,
    input  logic [msb_pkg::BYTE_W-1:0]        i_sprite_mask,
    input  logic                              i_row_end,
    // Result words.
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [msb_pkg::BYTE_W-1:0]        o_read_data,
    output logic                              o_clipped
);

    localparam int IDX_W = msb_pkg::PADDR_W - 2;

    logic [msb_pkg::POS_W-1:0] r_pos_x;
    logic [msb_pkg::POS_W-1:0] r_pos_y;
    logic                      cfg_write;
    logic [IDX_W-1:0]          reg_idx;
    msb_pkg::t_cfg             cfg;

    // The port never stalls, so a write lands on the access cycle.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_idx   = paddr[msb_pkg::PADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x <= '0;
            r_pos_y <= '0;
        end else if (cfg_write) begin
            if (int'(reg_idx) == msb_pkg::REG_POS_X) begin
                r_pos_x <= pwdata[msb_pkg::POS_W-1:0];
            end
            if (int'(reg_idx) == msb_pkg::REG_POS_Y) begin
                r_pos_y <= pwdata[msb_pkg::POS_W-1:0];
            end
        end
    end

    // Reads return the register value, zero-extended; the low two address bits are ignored.
    always_comb begin
        prdata = '0;
        case (int'(reg_idx))
            msb_pkg::REG_POS_X: prdata = msb_pkg::PDATA_W'(r_pos_x);
            msb_pkg::REG_POS_Y: prdata = msb_pkg::PDATA_W'(r_pos_y);
            default:            prdata = '0;
        endcase
    end

    assign cfg.pos_x = r_pos_x;
    assign cfg.pos_y = r_pos_y;

    msb_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_action     (i_action),
        .i_address    (i_address),
        .i_write_byte (i_write_byte),
        .i_sprite_row (i_sprite_row),
        .i_sprite_col (i_sprite_col),
        .i_sprite_data(i_sprite_data),
        .i_sprite_mask(i_sprite_mask),
        .i_row_end    (i_row_end),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_read_data  (o_read_data),
        .o_clipped    (o_clipped)
    );

endmodule

// ===== sim/masked_sprite_blitter_1bpp_core_test.sv =====
// Self-checking testbench of the masked one-bit sprite blitter core.
`timescale 1ns / 1ps
// A shadow copy of the framebuffer, the sprite carry and the position
// registers predicts the result word of every accepted input word. The test
// has four parts:
//   - reads right after reset, which must see the cleared framebuffer;
//   - byte writes and reads at the ends of the address range;
//   - blits at the framebuffer edges: no shift, carry and spill, and clipping;
//   - random traffic in three idling patterns.
// Most random words are complete sprite lines whose target bytes are then read
// back. The rest are random words of every action and broken sprite lines.
module masked_sprite_blitter_1bpp_core_test;

    // One input word, with the fields in port order.
    typedef struct packed {
        logic [msb_pkg::ACTION_W-1:0]  action;
        logic [msb_pkg::ADDRESS_W-1:0] address;
        logic [msb_pkg::BYTE_W-1:0]    write_byte;
        logic [msb_pkg::ROW_W-1:0]     row;
        logic [msb_pkg::COL_W-1:0]     col;
        logic [msb_pkg::BYTE_W-1:0]    data;
        logic [msb_pkg::BYTE_W-1:0]    mask;
        logic                          row_end;
    } t_word;

    // One result word.
    typedef struct packed {
        logic [msb_pkg::BYTE_W-1:0] read_data;
        logic                       clipped;
    } t_result;

    // The package names no code for the fourth action, which does nothing.
    localparam logic [msb_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;

    localparam int ITEMS_PER_PHASE = 610;
    localparam int ROUND_ITEMS     = 60;
    localparam int MAX_REPORTS     = 100;

    // Every input of the block holds a known value from time zero on.
    logic                          i_clk         = 1'b0;
    logic                          i_rst_n       = 1'b0;
    logic                          psel          = 1'b0;
    logic                          penable       = 1'b0;
    logic                          pwrite        = 1'b0;
    logic [msb_pkg::PADDR_W-1:0]   paddr         = '0;
    logic [msb_pkg::PDATA_W-1:0]   pwdata        = '0;
    logic [msb_pkg::PDATA_W-1:0]   prdata;
    logic                          pready;
    logic                          i_in_valid    = 1'b0;
    logic                          o_in_ready;
    logic [msb_pkg::ACTION_W-1:0]  i_action      = '0;
    logic [msb_pkg::ADDRESS_W-1:0] i_address     = '0;
    logic [msb_pkg::BYTE_W-1:0]    i_write_byte  = '0;
    logic [msb_pkg::ROW_W-1:0]     i_sprite_row  = '0;
    logic [msb_pkg::COL_W-1:0]     i_sprite_col  = '0;
    logic [msb_pkg::BYTE_W-1:0]    i_sprite_data = '0;
    logic [msb_pkg::BYTE_W-1:0]    i_sprite_mask = '0;
    logic                          i_row_end     = 1'b0;
    logic                          o_out_valid;
    logic                          i_out_ready   = 1'b0;
    logic [msb_pkg::BYTE_W-1:0]    o_read_data;
    logic                          o_clipped;

    // Shadow state of the block.
    logic [msb_pkg::BYTE_W-1:0] shadow_frame [msb_pkg::STORE_BYTES];
    logic [msb_pkg::BYTE_W-1:0] shadow_carry_data;
    logic [msb_pkg::BYTE_W-1:0] shadow_carry_mask;
    logic [msb_pkg::POS_W-1:0]  shadow_pos_x;
    logic [msb_pkg::POS_W-1:0]  shadow_pos_y;

    // Results of the accepted words that have not come out yet, oldest first.
    t_result pending_results [$];

    int error_count   = 0;
    int words_sent    = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    masked_sprite_blitter_1bpp_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_action      (i_action),
        .i_address     (i_address),
        .i_write_byte  (i_write_byte),
        .i_sprite_row  (i_sprite_row),
        .i_sprite_col  (i_sprite_col),
        .i_sprite_data (i_sprite_data),
        .i_sprite_mask (i_sprite_mask),
        .i_row_end     (i_row_end),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_read_data   (o_read_data),
        .o_clipped     (o_clipped)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // The run must end well within this time, clearing pass included.
    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what,
                                   input logic [msb_pkg::BYTE_W-1:0] got,
                                   input logic [msb_pkg::BYTE_W-1:0] want);
        if (error_count < MAX_REPORTS) begin
            $display("mismatch in %s at %0t ns: got %h, expected %h", what, $time, got, want);
        end
        error_count++;
    endtask

    // Merges one byte into the shadow framebuffer and returns 1 when the
    // target lies outside it, in which case nothing is written.
    function automatic logic merge_shadow_byte(input int line, input int column,
                                               input logic [msb_pkg::BYTE_W-1:0] pixels,
                                               input logic [msb_pkg::BYTE_W-1:0] opacity);
        int idx;
        if (line >= msb_pkg::LINES || column >= msb_pkg::LINE_BYTES) begin
            return 1'b1;
        end
        idx = line * msb_pkg::LINE_BYTES + column;
        shadow_frame[idx] = (shadow_frame[idx] & ~opacity) | (pixels & opacity);
        return 1'b0;
    endfunction

    // Applies one accepted word to the shadow state and returns its result.
    function automatic t_result apply_word(input t_word w);
        t_result                      res;
        int                           shift;
        int                           line;
        int                           column;
        logic [2*msb_pkg::BYTE_W-1:0] pixel_span;
        logic [2*msb_pkg::BYTE_W-1:0] opacity_span;
        res = '0;
        case (w.action)
            msb_pkg::ACT_WRITE: begin
                if (w.address < msb_pkg::STORE_BYTES) begin
                    shadow_frame[w.address] = w.write_byte;
                end
            end
            msb_pkg::ACT_READ: begin
                if (w.address < msb_pkg::STORE_BYTES) begin
                    res.read_data = shadow_frame[w.address];
                end
            end
            msb_pkg::ACT_BLIT: begin
                shift  = shadow_pos_x % 8;
                line   = shadow_pos_y + w.row;
                column = shadow_pos_x / 8 + w.col;
                if (w.col == 0) begin
                    shadow_carry_data = '0;
                    shadow_carry_mask = '0;
                end
                // The upper byte of each span is the shifted byte itself; the
                // lower byte holds the bits pushed into the next column.
                pixel_span   = {w.data, {msb_pkg::BYTE_W{1'b0}}} >> shift;
                opacity_span = {w.mask, {msb_pkg::BYTE_W{1'b0}}} >> shift;
                res.clipped = merge_shadow_byte(line, column,
                    pixel_span[2*msb_pkg::BYTE_W-1:msb_pkg::BYTE_W] | shadow_carry_data,
                    opacity_span[2*msb_pkg::BYTE_W-1:msb_pkg::BYTE_W] | shadow_carry_mask);
                if (w.row_end) begin
                    // Without a shift there is no spill byte to merge.
                    if (shift != 0) begin
                        res.clipped |= merge_shadow_byte(line, column + 1,
                                                         pixel_span[msb_pkg::BYTE_W-1:0],
                                                         opacity_span[msb_pkg::BYTE_W-1:0]);
                    end
                    shadow_carry_data = '0;
                    shadow_carry_mask = '0;
                end else begin
                    shadow_carry_data = pixel_span[msb_pkg::BYTE_W-1:0];
                    shadow_carry_mask = opacity_span[msb_pkg::BYTE_W-1:0];
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    // Presents one word after a random gap and waits until it is taken. Valid
    // stays high after acceptance so that back-to-back words need no gap; the
    // next call or the drain lowers it.
    task automatic send_word(input t_word w);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_action      <= w.action;
        i_address     <= w.address;
        i_write_byte  <= w.write_byte;
        i_sprite_row  <= w.row;
        i_sprite_col  <= w.col;
        i_sprite_data <= w.data;
        i_sprite_mask <= w.mask;
        i_row_end     <= w.row_end;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        pending_results.push_back(apply_word(w));
        words_sent++;
    endtask

    task automatic send_access(input logic [msb_pkg::ACTION_W-1:0] action,
                               input logic [msb_pkg::ADDRESS_W-1:0] address,
                               input logic [msb_pkg::BYTE_W-1:0] value);
        t_word w;
        w            = '0;
        w.action     = action;
        w.address    = address;
        w.write_byte = value;
        send_word(w);
    endtask

    task automatic send_blit(input logic [msb_pkg::ROW_W-1:0] row,
                             input logic [msb_pkg::COL_W-1:0] column,
                             input logic [msb_pkg::BYTE_W-1:0] pixels,
                             input logic [msb_pkg::BYTE_W-1:0] opacity,
                             input logic line_end);
        t_word w;
        w         = '0;
        w.action  = msb_pkg::ACT_BLIT;
        w.row     = row;
        w.col     = column;
        w.data    = pixels;
        w.mask    = opacity;
        w.row_end = line_end;
        send_word(w);
    endtask

    // Stops sending and waits until every pending result has come out.
    task automatic hold_until_drained();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Setup and access cycle of one register write. The select lines stay up
    // so that a second write can follow at once; set_position lowers them.
    task automatic write_register(input int index, input logic [msb_pkg::PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= msb_pkg::PADDR_W'(index * 4);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
    endtask

    // The registers are only written while the block holds no word.
    task automatic set_position(input logic [msb_pkg::POS_W-1:0] x,
                                input logic [msb_pkg::POS_W-1:0] y);
        hold_until_drained();
        write_register(msb_pkg::REG_POS_X, msb_pkg::PDATA_W'(x));
        write_register(msb_pkg::REG_POS_Y, msb_pkg::PDATA_W'(y));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        shadow_pos_x = x;
        shadow_pos_y = y;
    endtask

    function automatic logic [msb_pkg::POS_W-1:0] pick_position();
        if ($urandom_range(3) == 0) begin
            return ($urandom_range(1) != 0) ? msb_pkg::POS_W'(127) : msb_pkg::POS_W'(0);
        end
        return msb_pkg::POS_W'($urandom_range(127));
    endfunction

    function automatic logic [msb_pkg::BYTE_W-1:0] random_byte();
        case ($urandom_range(5))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return msb_pkg::BYTE_W'($urandom);
        endcase
    endfunction

    // A word with every field random, action included.
    function automatic t_word random_word();
        logic [63:0] bits;
        bits = {$urandom, $urandom};
        return bits[$bits(t_word)-1:0];
    endfunction

    // Blits a sprite of a few lines, then reads back every byte an unbroken one can reach.
    // One sprite in eight is broken: random columns and random row ends.
    task automatic send_random_sprite();
        int                        span;
        int                        height;
        int                        first_row;
        int                        line;
        int                        column;
        bit                        broken;
        logic [msb_pkg::COL_W-1:0] col_sent;
        logic                      line_end;
        span      = ($urandom_range(7) == 0) ? $urandom_range(16, 5) : $urandom_range(3, 1);
        height    = $urandom_range(3, 1);
        first_row = $urandom_range(127);
        broken    = ($urandom_range(7) == 0);
        for (int r = 0; r < height; r++) begin
            for (int c = 0; c < span; c++) begin
                col_sent = msb_pkg::COL_W'(c);
                line_end = (c == span - 1);
                if (broken) begin
                    if ($urandom_range(1) != 0) begin
                        col_sent = msb_pkg::COL_W'($urandom_range(15));
                    end
                    line_end = ($urandom_range(1) != 0);
                end
                send_blit(msb_pkg::ROW_W'(first_row + r), col_sent, random_byte(),
                          random_byte(), line_end);
            end
        end
        for (int r = 0; r < height; r++) begin
            line = shadow_pos_y + ((first_row + r) % 128);
            for (int c = 0; c <= span; c++) begin
                column = shadow_pos_x / 8 + c;
                if (line < msb_pkg::LINES && column < msb_pkg::LINE_BYTES) begin
                    send_access(msb_pkg::ACT_READ,
                                msb_pkg::ADDRESS_W'(line * msb_pkg::LINE_BYTES + column),
                                8'h00);
                end
            end
        end
    endtask

    // The registers are written during the clearing pass; the reads wait for
    // it to finish and must then see the fill value.
    task automatic test_fill_after_reset();
        set_position(0, 0);
        send_access(msb_pkg::ACT_READ, 0, 8'h00);
        send_access(msb_pkg::ACT_READ, 2047, 8'h00);
        send_access(msb_pkg::ACT_READ, msb_pkg::ADDRESS_W'($urandom_range(2046, 1)), 8'h00);
    endtask

    task automatic test_byte_access();
        t_word w;
        send_access(msb_pkg::ACT_WRITE, 0, 8'h00);
        send_access(msb_pkg::ACT_WRITE, 2047, 8'hAA);
        send_access(msb_pkg::ACT_WRITE, 1, 8'h55);
        send_access(msb_pkg::ACT_READ, 0, 8'hFF);
        send_access(msb_pkg::ACT_READ, 2047, 8'h00);
        send_access(msb_pkg::ACT_READ, 1, 8'h00);
        // The unused action leaves everything alone and returns zeros.
        w = random_word();
        w.action = ACT_UNUSED;
        send_word(w);
    endtask

    task automatic test_blit_edges();
        // With no shift the row end has no spill byte and flags nothing.
        set_position(0, 0);
        send_blit(0, 0, 8'hA5, 8'hF0, 1'b1);
        send_access(msb_pkg::ACT_READ, 0, 8'h00);
        // A shift of three carries bits between columns and spills at row end.
        set_position(3, 5);
        send_blit(0, 0, 8'hFF, 8'hFF, 1'b0);
        send_blit(0, 1, 8'h00, 8'hFF, 1'b0);
        send_blit(0, 2, 8'h0F, 8'h3C, 1'b1);
        // The row end has emptied the carry, even though this is no column zero.
        send_blit(0, 3, 8'h80, 8'h80, 1'b0);
        for (int c = 0; c < 4; c++) begin
            send_access(msb_pkg::ACT_READ,
                        msb_pkg::ADDRESS_W'(5 * msb_pkg::LINE_BYTES + c), 8'h00);
        end
        // Last column: the byte lands, its spill falls off the right edge.
        set_position(127, 0);
        send_blit(0, 0, 8'h81, 8'hFF, 1'b1);
        send_access(msb_pkg::ACT_READ, 15, 8'h00);
        // Bottom edge: the last line is written, the lines below are clipped.
        set_position(8, 127);
        send_blit(0, 0, 8'h00, 8'hFF, 1'b1);
        send_blit(1, 0, 8'h00, 8'hFF, 1'b1);
        send_blit(127, 15, 8'hFF, 8'hFF, 1'b1);
        send_access(msb_pkg::ACT_READ,
                    msb_pkg::ADDRESS_W'(127 * msb_pkg::LINE_BYTES + 1), 8'h00);
    endtask

    // Rounds of random traffic, each at a new position. Every round starts
    // with the sender held back until all results are in.
    task automatic test_random_traffic(input int send_pct, input int recv_pct);
        int phase_end;
        int round_end;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        phase_end = words_sent + ITEMS_PER_PHASE;
        while (words_sent < phase_end) begin
            set_position(pick_position(), pick_position());
            round_end = words_sent + ROUND_ITEMS;
            while (words_sent < round_end) begin
                if ($urandom_range(9) < 7) begin
                    send_random_sprite();
                end else begin
                    repeat ($urandom_range(4, 1)) send_word(random_word());
                end
            end
        end
    endtask

    // Result side: random ready, and a check of every word taken. Values seen
    // here are the ones that stood before the clock edge.
    always @(posedge i_clk) begin : check_results
        t_result want;
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result word with nothing pending", o_read_data, 8'h00);
            end else begin
                want = pending_results.pop_front();
                if (o_read_data !== want.read_data) begin
                    report_mismatch("read_data", o_read_data, want.read_data);
                end
                if (o_clipped !== want.clipped) begin
                    report_mismatch("clipped", msb_pkg::BYTE_W'(o_clipped),
                                    msb_pkg::BYTE_W'(want.clipped));
                end
            end
        end
    end

    initial begin
        foreach (shadow_frame[i]) begin
            shadow_frame[i] = msb_pkg::FILL_BYTE;
        end
        shadow_carry_data = '0;
        shadow_carry_mask = '0;
        shadow_pos_x      = '0;
        shadow_pos_y      = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_fill_after_reset();
        test_byte_access();
        test_blit_edges();
        test_random_traffic(37, 65);
        test_random_traffic(65, 37);
        test_random_traffic(0, 0);

        // After the drain the bench idles on, so that a stray extra result would be seen.
        hold_until_drained();
        repeat (4) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/msb_pkg.sv
rtl/msb_frame_ram.sv
rtl/msb_engine.sv
rtl/masked_sprite_blitter_1bpp_core.sv
sim/masked_sprite_blitter_1bpp_core_test.sv
